// ===== rtl/wav_header_parser_top_defines.svh =====
`ifndef WAV_HEADER_PARSER_TOP_DEFINES_SVH
`define WAV_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define WAVP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wav header parser: check failed");

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define WAVP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wav header parser: check failed");

`endif

// ===== rtl/wavp_pkg.sv =====
package wavp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_FTAG  = 4'd3,
    PH_FSIZE = 4'd4,
    PH_FSKIP = 4'd5,
    PH_FMT   = 4'd6,
    PH_DTAG  = 4'd7,
    PH_DSIZE = 4'd8,
    PH_DSKIP = 4'd9,
    PH_DATA  = 4'd10,
    PH_DONE  = 4'd11
  } phase_e;

  typedef enum logic [3:0] {
    ST_HEADER  = 4'd0,
    ST_DATA    = 4'd1,
    ST_NORIFF  = 4'd2,
    ST_NOWAVE  = 4'd3,
    ST_NOFMT   = 4'd4,
    ST_NOTPCM  = 4'd5,
    ST_BADCHAN = 4'd6,
    ST_BADBITS = 4'd7,
    ST_NODATA  = 4'd8,
    ST_ZEROCHK = 4'd9,
    ST_EMPTY   = 4'd10,
    ST_TRUNC   = 4'd11,
    ST_IGNORED = 4'd12
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  data_byte;
    logic        data_last;
    logic        is_stereo;
    logic        is_16bit;
    logic [31:0] sample_rate;
  } result_t;

endpackage

// ===== rtl/wav_header_parser_top.sv =====
// Channel   Direction  Handshake                 Beat payload
// input     in         in_valid_i / in_stall_o   byte_value_i, end_of_file_i
// result    out        out_valid_o / out_stall_i status_o, data_byte_o, data_last_o,
//                                                is_stereo_o, is_16bit_o, sample_rate_o
//
// One result beat per input beat; a new byte is taken every cycle while in_stall_o is low.
// The parser state updates and the result is registered in the same edge.
// A two-entry output buffer keeps input flowing through a result stall until
// its second entry fills; in_stall_o only rises when both entries hold.
// rst_ni clears the parser to expect the RIFF tag; end_of_file re-arms it.

module wav_header_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [7:0]  data_byte_o,
  output logic        data_last_o,
  output logic        is_stereo_o,
  output logic        is_16bit_o,
  output logic [31:0] sample_rate_o
);

  wavp_pkg::result_t core_res;
  wavp_pkg::result_t out_res;
  logic              acc;

  assign acc = in_valid_i && !in_stall_o;

  wavp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .byte_value_i  (byte_value_i),
    .end_of_file_i (end_of_file_i),
    .res_o         (core_res)
  );

  wavp_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_res_i   (core_res),
    .push_stall_o (in_stall_o),
    .pop_valid_o  (out_valid_o),
    .pop_stall_i  (out_stall_i),
    .pop_res_o    (out_res)
  );

  assign status_o      = out_res.status;
  assign data_byte_o   = out_res.data_byte;
  assign data_last_o   = out_res.data_last;
  assign is_stereo_o   = out_res.is_stereo;
  assign is_16bit_o    = out_res.is_16bit;
  assign sample_rate_o = out_res.sample_rate;

endmodule

// ===== rtl/wavp_core.sv =====
`include "wav_header_parser_top_defines.svh"

module wavp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [7:0]       byte_value_i,
  input  logic             end_of_file_i,
  output wavp_pkg::result_t res_o
);

  wavp_pkg::phase_e  phase_q, phase_d;
  wavp_pkg::status_e err_q, err_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] size_q, size_d;
  logic [31:0] remain_q, remain_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] rate_q, rate_d;

  wavp_pkg::status_e st;
  wavp_pkg::status_e fail_code;
  logic        fail;
  logic        last;
  logic        meta;
  logic [7:0]  db;
  logic        grp_done;
  logic [31:0] tag_sh, size_sh, rem_dec;
  logic        rem_zero;
  logic [3:0]  off;
  logic [15:0] fmt_n, chan_n, bits_n;
  logic [31:0] rate_n;

  assign grp_done = (cnt_q == 2'd3);
  assign tag_sh   = {tag_q[23:0], byte_value_i};
  assign size_sh  = {byte_value_i, size_q[31:8]};
  assign rem_dec  = remain_q - 32'd1;
  assign rem_zero = (rem_dec == 32'd0);
  assign off      = 4'(5'd16 - remain_q[4:0]);

  // Merge the current byte into the fmt body fields (little endian).
  always_comb begin
    fmt_n  = fmt_q;
    chan_n = chan_q;
    rate_n = rate_q;
    bits_n = bits_q;
    if (off < 4'd2) begin
      fmt_n = fmt_q | ({8'd0, byte_value_i} << {off[0], 3'b000});
    end else if (off < 4'd4) begin
      chan_n = chan_q | ({8'd0, byte_value_i} << {off[0], 3'b000});
    end else if (off < 4'd8) begin
      rate_n = rate_q | ({24'd0, byte_value_i} << {off[1:0], 3'b000});
    end else if (off >= 4'd14) begin
      bits_n = bits_q | ({8'd0, byte_value_i} << {off[0], 3'b000});
    end
  end

  always_comb begin
    phase_d   = phase_q;
    err_d     = err_q;
    cnt_d     = cnt_q;
    tag_d     = tag_q;
    size_d    = size_q;
    remain_d  = remain_q;
    fmt_d     = fmt_q;
    chan_d    = chan_q;
    bits_d    = bits_q;
    rate_d    = rate_q;
    st        = wavp_pkg::ST_HEADER;
    fail      = 1'b0;
    fail_code = wavp_pkg::ST_HEADER;
    last      = 1'b0;
    meta      = 1'b0;
    db        = 8'd0;

    case (phase_q)
      wavp_pkg::PH_RIFF, wavp_pkg::PH_WAVE, wavp_pkg::PH_FTAG, wavp_pkg::PH_DTAG: begin
        tag_d = tag_sh;
        cnt_d = cnt_q + 2'd1;
        if (grp_done) begin
          case (phase_q)
            wavp_pkg::PH_RIFF: begin
              if (tag_sh == wavp_pkg::TAG_RIFF) begin
                phase_d = wavp_pkg::PH_RSIZE;
              end else begin
                fail      = 1'b1;
                fail_code = wavp_pkg::ST_NORIFF;
              end
            end
            wavp_pkg::PH_WAVE: begin
              if (tag_sh == wavp_pkg::TAG_WAVE) begin
                phase_d = wavp_pkg::PH_FTAG;
              end else begin
                fail      = 1'b1;
                fail_code = wavp_pkg::ST_NOWAVE;
              end
            end
            wavp_pkg::PH_FTAG: phase_d = wavp_pkg::PH_FSIZE;
            default:           phase_d = wavp_pkg::PH_DSIZE;
          endcase
        end
      end
      wavp_pkg::PH_RSIZE: begin
        cnt_d = cnt_q + 2'd1;
        if (grp_done) begin
          phase_d = wavp_pkg::PH_WAVE;
        end
      end
      wavp_pkg::PH_FSIZE, wavp_pkg::PH_DSIZE: begin
        size_d = size_sh;
        cnt_d  = cnt_q + 2'd1;
        if (grp_done) begin
          if (phase_q == wavp_pkg::PH_FSIZE && tag_q == wavp_pkg::TAG_FMT) begin
            remain_d = wavp_pkg::FMT_BODY_LEN;
            fmt_d    = 16'd0;
            chan_d   = 16'd0;
            bits_d   = 16'd0;
            rate_d   = 32'd0;
            phase_d  = wavp_pkg::PH_FMT;
          end else if (phase_q == wavp_pkg::PH_DSIZE && tag_q == wavp_pkg::TAG_DATA) begin
            if (size_sh == 32'd0) begin
              fail      = 1'b1;
              fail_code = wavp_pkg::ST_EMPTY;
            end else begin
              remain_d = size_sh;
              phase_d  = wavp_pkg::PH_DATA;
            end
          end else if (size_sh == 32'd0) begin
            fail      = 1'b1;
            fail_code = wavp_pkg::ST_ZEROCHK;
          end else begin
            remain_d = size_sh;
            phase_d  = (phase_q == wavp_pkg::PH_FSIZE) ? wavp_pkg::PH_FSKIP
                                                       : wavp_pkg::PH_DSKIP;
          end
        end
      end
      wavp_pkg::PH_FSKIP, wavp_pkg::PH_DSKIP: begin
        remain_d = rem_dec;
        if (rem_zero) begin
          phase_d = (phase_q == wavp_pkg::PH_FSKIP) ? wavp_pkg::PH_FTAG
                                                    : wavp_pkg::PH_DTAG;
        end
      end
      wavp_pkg::PH_FMT: begin
        fmt_d    = fmt_n;
        chan_d   = chan_n;
        rate_d   = rate_n;
        bits_d   = bits_n;
        remain_d = rem_dec;
        if (rem_zero) begin
          if (fmt_n != 16'd1) begin
            fail      = 1'b1;
            fail_code = wavp_pkg::ST_NOTPCM;
          end else if (chan_n != 16'd1 && chan_n != 16'd2) begin
            fail      = 1'b1;
            fail_code = wavp_pkg::ST_BADCHAN;
          end else if (bits_n != 16'd8 && bits_n != 16'd16) begin
            fail      = 1'b1;
            fail_code = wavp_pkg::ST_BADBITS;
          end else if (size_q > wavp_pkg::FMT_BODY_LEN) begin
            // skip the fmt bytes past the parsed body
            remain_d = size_q - wavp_pkg::FMT_BODY_LEN;
            phase_d  = wavp_pkg::PH_DSKIP;
          end else begin
            phase_d = wavp_pkg::PH_DTAG;
          end
        end
      end
      wavp_pkg::PH_DATA: begin
        st       = wavp_pkg::ST_DATA;
        db       = byte_value_i;
        meta     = 1'b1;
        remain_d = rem_dec;
        if (rem_zero) begin
          last    = 1'b1;
          phase_d = wavp_pkg::PH_DONE;
        end
      end
      default: begin
        st = (err_q != wavp_pkg::ST_HEADER) ? err_q : wavp_pkg::ST_IGNORED;
      end
    endcase

    if (fail) begin
      st      = fail_code;
      err_d   = fail_code;
      phase_d = wavp_pkg::PH_DONE;
    end

    // End of file: report what was missing, or cut the data run short.
    if (end_of_file_i) begin
      if (st == wavp_pkg::ST_HEADER) begin
        if (phase_d == wavp_pkg::PH_RIFF) begin
          st = wavp_pkg::ST_NORIFF;
        end else if (phase_d <= wavp_pkg::PH_WAVE) begin
          st = wavp_pkg::ST_NOWAVE;
        end else if (phase_d <= wavp_pkg::PH_FMT) begin
          st = wavp_pkg::ST_NOFMT;
        end else begin
          st = wavp_pkg::ST_NODATA;
        end
      end else if (st == wavp_pkg::ST_DATA && !last) begin
        st   = wavp_pkg::ST_TRUNC;
        last = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.status      = st;
    res_o.data_byte   = db;
    res_o.data_last   = last;
    res_o.is_stereo   = meta && (chan_q == 16'd2);
    res_o.is_16bit    = meta && (bits_q == 16'd16);
    res_o.sample_rate = meta ? rate_q : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wavp_pkg::PH_RIFF;
      err_q    <= wavp_pkg::ST_HEADER;
      cnt_q    <= 2'd0;
      tag_q    <= 32'd0;
      size_q   <= 32'd0;
      remain_q <= 32'd0;
      fmt_q    <= 16'd0;
      chan_q   <= 16'd0;
      bits_q   <= 16'd0;
      rate_q   <= 32'd0;
    end else if (acc_i) begin
      if (end_of_file_i) begin
        // re-arm for the next file
        phase_q  <= wavp_pkg::PH_RIFF;
        err_q    <= wavp_pkg::ST_HEADER;
        cnt_q    <= 2'd0;
        tag_q    <= 32'd0;
        size_q   <= 32'd0;
        remain_q <= 32'd0;
        fmt_q    <= 16'd0;
        chan_q   <= 16'd0;
        bits_q   <= 16'd0;
        rate_q   <= 32'd0;
      end else begin
        phase_q  <= phase_d;
        err_q    <= err_d;
        cnt_q    <= cnt_d;
        tag_q    <= tag_d;
        size_q   <= size_d;
        remain_q <= remain_d;
        fmt_q    <= fmt_d;
        chan_q   <= chan_d;
        bits_q   <= bits_d;
        rate_q   <= rate_d;
      end
    end
  end

  `WAVP_ASSERT_IMPL(a_last_on_data, acc_i && res_o.data_last,
    res_o.status == wavp_pkg::ST_DATA || res_o.status == wavp_pkg::ST_TRUNC)
  `WAVP_ASSERT_NEXT(a_eof_rearm, acc_i && end_of_file_i,
    phase_q == wavp_pkg::PH_RIFF && cnt_q == 2'd0)
  `WAVP_ASSERT_IMPL(a_count_live,
    phase_q == wavp_pkg::PH_FSKIP || phase_q == wavp_pkg::PH_DSKIP ||
    phase_q == wavp_pkg::PH_FMT || phase_q == wavp_pkg::PH_DATA,
    remain_q != 32'd0)

endmodule

// ===== rtl/wavp_skid.sv =====
`include "wav_header_parser_top_defines.svh"

module wavp_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  wavp_pkg::result_t push_res_i,
  output logic              push_stall_o,
  output logic              pop_valid_o,
  input  logic              pop_stall_i,
  output wavp_pkg::result_t pop_res_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  wavp_pkg::result_t out_q, out_d;
  wavp_pkg::result_t skid_q, skid_d;
  logic              push;
  logic              pop;

  assign push_stall_o = skid_valid_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign pop          = out_valid_q && !pop_stall_i;
  assign pop_valid_o  = out_valid_q;
  assign pop_res_o    = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // drain the skid beat into the output register
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_d       = push_res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `WAVP_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q)
  `WAVP_ASSERT_NEXT(a_skid_drains, skid_valid_q && !pop_stall_i, !skid_valid_q && out_valid_q)
  `WAVP_ASSERT_NEXT(a_out_held, pop_valid_o && pop_stall_i, pop_valid_o && $stable(pop_res_o))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEM_TARGET = 1250;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } file_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  byte_value_i = 8'h00;
  logic        end_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  status_o;
  logic [7:0]  data_byte_o;
  logic        data_last_o;
  logic        is_stereo_o;
  logic        is_16bit_o;
  logic [31:0] sample_rate_o;

  wav_header_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_value_i  (byte_value_i),
    .end_of_file_i (end_of_file_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .data_byte_o   (data_byte_o),
    .data_last_o   (data_last_o),
    .is_stereo_o   (is_stereo_o),
    .is_16bit_o    (is_16bit_o),
    .sample_rate_o (sample_rate_o)
  );

  always #5 clk_i = ~clk_i;

  file_beat_t         file_stream_q[$];
  wavp_pkg::result_t  parsed_results_q[$];
  logic [7:0]         file_buf[$];

  int unsigned files_built;
  int unsigned bytes_queued;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned status_seen[16];

  // Shadow of the parser state
  wavp_pkg::phase_e  ps_phase;
  logic [2:0]        ps_cnt;
  logic [31:0]       ps_tag;
  logic [31:0]       ps_size;
  logic [31:0]       ps_left;
  logic [15:0]       ps_fmt;
  logic [15:0]       ps_chan;
  logic [15:0]       ps_bits;
  logic [31:0]       ps_rate;
  wavp_pkg::status_e ps_err;

  function automatic void parser_clear();
    ps_phase = wavp_pkg::PH_RIFF;
    ps_cnt   = '0;
    ps_tag   = '0;
    ps_size  = '0;
    ps_left  = '0;
    ps_fmt   = '0;
    ps_chan  = '0;
    ps_bits  = '0;
    ps_rate  = '0;
    ps_err   = wavp_pkg::ST_HEADER;
  endfunction

  function automatic logic group_complete();
    ps_cnt = ps_cnt + 3'd1;
    if (ps_cnt >= 3'd4) begin
      ps_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic wavp_pkg::status_e abort_parse(wavp_pkg::status_e code);
    ps_err   = code;
    ps_phase = wavp_pkg::PH_DONE;
    return code;
  endfunction

  function automatic wavp_pkg::result_t parse_wav_byte(logic [7:0] b, logic eof);
    wavp_pkg::result_t r;
    logic    meta;
    logic [3:0] off;
    r    = '0;
    meta = 1'b0;
    case (ps_phase)
      wavp_pkg::PH_RIFF, wavp_pkg::PH_WAVE, wavp_pkg::PH_FTAG, wavp_pkg::PH_DTAG: begin
        ps_tag = {ps_tag[23:0], b};
        if (group_complete()) begin
          if (ps_phase == wavp_pkg::PH_RIFF) begin
            if (ps_tag == wavp_pkg::TAG_RIFF) ps_phase = wavp_pkg::PH_RSIZE;
            else r.status = abort_parse(wavp_pkg::ST_NORIFF);
          end else if (ps_phase == wavp_pkg::PH_WAVE) begin
            if (ps_tag == wavp_pkg::TAG_WAVE) ps_phase = wavp_pkg::PH_FTAG;
            else r.status = abort_parse(wavp_pkg::ST_NOWAVE);
          end else begin
            ps_phase = wavp_pkg::phase_e'(ps_phase + 4'd1);
          end
        end
      end
      wavp_pkg::PH_RSIZE: begin
        if (group_complete()) ps_phase = wavp_pkg::PH_WAVE;
      end
      wavp_pkg::PH_FSIZE, wavp_pkg::PH_DSIZE: begin
        ps_size = {b, ps_size[31:8]};
        if (group_complete()) begin
          if (ps_phase == wavp_pkg::PH_FSIZE && ps_tag == wavp_pkg::TAG_FMT) begin
            ps_left  = wavp_pkg::FMT_BODY_LEN;
            ps_fmt   = '0;
            ps_chan  = '0;
            ps_bits  = '0;
            ps_rate  = '0;
            ps_phase = wavp_pkg::PH_FMT;
          end else if (ps_phase == wavp_pkg::PH_DSIZE && ps_tag == wavp_pkg::TAG_DATA) begin
            if (ps_size == 0) begin
              r.status = abort_parse(wavp_pkg::ST_EMPTY);
            end else begin
              ps_left  = ps_size;
              ps_phase = wavp_pkg::PH_DATA;
            end
          end else if (ps_size == 0) begin
            r.status = abort_parse(wavp_pkg::ST_ZEROCHK);
          end else begin
            ps_left  = ps_size;
            ps_phase = wavp_pkg::phase_e'(ps_phase + 4'd1);
          end
        end
      end
      wavp_pkg::PH_FSKIP, wavp_pkg::PH_DSKIP: begin
        ps_left = ps_left - 1;
        if (ps_left == 0)
          ps_phase = (ps_phase == wavp_pkg::PH_FSKIP) ? wavp_pkg::PH_FTAG
                                                      : wavp_pkg::PH_DTAG;
      end
      wavp_pkg::PH_FMT: begin
        off = 4'(wavp_pkg::FMT_BODY_LEN - ps_left);
        if (off < 2) ps_fmt |= 16'(b) << (8 * off);
        else if (off < 4) ps_chan |= 16'(b) << (8 * (off - 2));
        else if (off < 8) ps_rate |= 32'(b) << (8 * (off - 4));
        else if (off >= 14) ps_bits |= 16'(b) << (8 * (off - 14));
        ps_left = ps_left - 1;
        if (ps_left == 0) begin
          if (ps_fmt != 16'd1) begin
            r.status = abort_parse(wavp_pkg::ST_NOTPCM);
          end else if (ps_chan != 16'd1 && ps_chan != 16'd2) begin
            r.status = abort_parse(wavp_pkg::ST_BADCHAN);
          end else if (ps_bits != 16'd8 && ps_bits != 16'd16) begin
            r.status = abort_parse(wavp_pkg::ST_BADBITS);
          end else if (ps_size > wavp_pkg::FMT_BODY_LEN) begin
            // extra fmt bytes are skipped on the way to the data tag
            ps_left  = ps_size - wavp_pkg::FMT_BODY_LEN;
            ps_phase = wavp_pkg::PH_DSKIP;
          end else begin
            ps_phase = wavp_pkg::PH_DTAG;
          end
        end
      end
      wavp_pkg::PH_DATA: begin
        r.status    = wavp_pkg::ST_DATA;
        r.data_byte = b;
        meta        = 1'b1;
        ps_left     = ps_left - 1;
        if (ps_left == 0) begin
          r.data_last = 1'b1;
          ps_phase    = wavp_pkg::PH_DONE;
        end
      end
      default: begin
        r.status = (ps_err != wavp_pkg::ST_HEADER) ? ps_err : wavp_pkg::ST_IGNORED;
      end
    endcase

    if (eof) begin
      if (r.status == wavp_pkg::ST_HEADER) begin
        if (ps_phase == wavp_pkg::PH_RIFF) r.status = wavp_pkg::ST_NORIFF;
        else if (ps_phase <= wavp_pkg::PH_WAVE) r.status = wavp_pkg::ST_NOWAVE;
        else if (ps_phase <= wavp_pkg::PH_FMT) r.status = wavp_pkg::ST_NOFMT;
        else r.status = wavp_pkg::ST_NODATA;
      end else if (r.status == wavp_pkg::ST_DATA && !r.data_last) begin
        r.status    = wavp_pkg::ST_TRUNC;
        r.data_last = 1'b1;
      end
    end

    r.is_stereo   = meta && ps_chan == 16'd2;
    r.is_16bit    = meta && ps_bits == 16'd16;
    r.sample_rate = meta ? ps_rate : 32'd0;
    if (eof) parser_clear();
    return r;
  endfunction

  // File assembly

  function automatic logic chance(int unsigned n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic void put_tag(logic [31:0] tag);
    for (int i = 3; i >= 0; i--) file_buf.push_back(tag[8*i +: 8]);
  endfunction

  function automatic void put_le(logic [31:0] v, int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) file_buf.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_random(int unsigned n);
    repeat (n) file_buf.push_back(8'($urandom));
  endfunction

  function automatic void put_side_chunk(logic [31:0] avoid);
    logic [31:0] tag;
    int unsigned sz;
    tag = chance(3) ? 32'h4C49_5354 : $urandom;
    if (tag == avoid) tag = tag ^ 32'h1;
    sz = chance(16) ? 0 : $urandom_range(1, 8);
    put_tag(tag);
    put_le(sz, 4);
    put_random(sz);
  endfunction

  // Hand the assembled bytes to the driver, end of file at the cut point
  function automatic void commit_file(int unsigned cut);
    for (int unsigned i = 0; i < cut; i++)
      file_stream_q.push_back('{value: file_buf[i], last: (i == cut - 1)});
    bytes_queued += cut;
    files_built++;
    file_buf.delete();
  endfunction

  function automatic void build_wav_file();
    int unsigned fmt_size;
    int unsigned pick;
    logic [31:0] data_size;
    int unsigned data_sent;
    put_tag(chance(30) ? $urandom : wavp_pkg::TAG_RIFF);
    put_le($urandom, 4);
    put_tag(chance(30) ? $urandom : wavp_pkg::TAG_WAVE);
    repeat ($urandom_range(0, 2)) put_side_chunk(wavp_pkg::TAG_FMT);

    put_tag(chance(25) ? $urandom : wavp_pkg::TAG_FMT);
    case ($urandom_range(0, 7))
      0: fmt_size = $urandom_range(0, 15);
      1: fmt_size = $urandom_range(17, 24);
      default: fmt_size = 16;
    endcase
    put_le(fmt_size, 4);
    put_le(chance(12) ? $urandom : 32'd1, 2);
    pick = $urandom_range(0, 19);
    put_le(pick == 0 ? $urandom : pick == 1 ? 3 * $urandom_range(0, 1)
                                            : $urandom_range(1, 2), 2);
    put_le($urandom, 4);
    put_random(6);
    pick = $urandom_range(0, 19);
    put_le(pick == 0 ? $urandom : pick == 1 ? $urandom_range(0, 32)
                                            : 8 * $urandom_range(1, 2), 2);
    if (fmt_size > 16) put_random(fmt_size - 16);

    repeat ($urandom_range(0, 2)) put_side_chunk(wavp_pkg::TAG_DATA);
    put_tag(chance(25) ? $urandom : wavp_pkg::TAG_DATA);
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      data_size = 0;
      data_sent = 0;
    end else if (pick == 1) begin
      // long declared run that the file cuts short
      data_size = $urandom | 32'h100;
      data_sent = $urandom_range(1, 12);
    end else begin
      data_size = $urandom_range(1, 20);
      data_sent = data_size;
    end
    put_le(data_size, 4);
    put_random(data_sent);
    if (data_sent == data_size && chance(3)) put_random($urandom_range(1, 4));

    commit_file(chance(5) ? $urandom_range(1, file_buf.size()) : file_buf.size());
  endfunction

  // Input side: driver

  logic        in_beat_done = 1'b0;
  logic        in_burst = 1'b0;
  int unsigned in_gap = 0;

  always @(negedge clk_i) begin
    file_beat_t beat;
    if (rst_ni) begin
      if (in_valid_i && !in_beat_done) begin
        // hold the stalled beat
      end else if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (file_stream_q.size() != 0) begin
        beat           = file_stream_q.pop_front();
        in_valid_i    <= 1'b1;
        byte_value_i  <= beat.value;
        end_of_file_i <= beat.last;
        if (chance(40)) in_burst <= ~in_burst;
        in_gap <= in_burst ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: stall generator

  logic        out_took = 1'b0;
  logic        out_burst = 1'b0;
  int unsigned out_hold = 0;

  always @(negedge clk_i) begin
    int unsigned n;
    if (rst_ni) begin
      if (out_took) begin
        if (chance(40)) out_burst <= ~out_burst;
        n = out_burst ? 0 : $urandom_range(0, 3);
        out_stall_i <= (n != 0);
        out_hold    <= (n == 0) ? 0 : n - 1;
      end else if (out_hold != 0) begin
        out_stall_i <= 1'b1;
        out_hold    <= out_hold - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Predict on accepted input beats, check accepted result beats

  always @(posedge clk_i) begin
    wavp_pkg::result_t want;
    if (rst_ni) begin
      in_beat_done <= in_valid_i && !in_stall_o;
      out_took     <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o)
        parsed_results_q.push_back(parse_wav_byte(byte_value_i, end_of_file_i));
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        status_seen[status_o]++;
        if (parsed_results_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result beat with nothing pending: status %0d byte %02h",
                     $time, status_o, data_byte_o);
        end else begin
          want = parsed_results_q.pop_front();
          if (status_o !== want.status || data_byte_o !== want.data_byte ||
              data_last_o !== want.data_last || is_stereo_o !== want.is_stereo ||
              is_16bit_o !== want.is_16bit || sample_rate_o !== want.sample_rate) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: mismatch exp st=%0d byte=%02h last=%b st2=%b w16=%b rate=%08h",
                       $time, want.status, want.data_byte, want.data_last,
                       want.is_stereo, want.is_16bit, want.sample_rate);
              $display("%0t:          got st=%0d byte=%02h last=%b st2=%b w16=%b rate=%08h",
                       $time, status_o, data_byte_o, data_last_o,
                       is_stereo_o, is_16bit_o, sample_rate_o);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, parsed_results_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    parser_clear();

    // Short broken files: lone bytes, bad RIFF tag, bad WAVE tag, end after the RIFF tag
    put_random(0);
    file_buf.push_back(8'h00);
    commit_file(1);
    file_buf.push_back(8'hFF);
    commit_file(1);
    put_tag(32'h5249_4658);
    file_buf.push_back(8'h00);
    commit_file(5);
    put_tag(wavp_pkg::TAG_RIFF);
    put_le(32'hFFFF_FFFF, 4);
    put_tag(32'h5741_5658);
    commit_file(12);
    put_tag(wavp_pkg::TAG_RIFF);
    commit_file(4);

    while (bytes_queued < ITEM_TARGET) begin
      if (chance(4)) begin
        if (chance(2)) file_buf.push_back(8'h52);
        put_random($urandom_range(1, 10));
        commit_file(file_buf.size());
      end else begin
        build_wav_file();
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (file_stream_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (parsed_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d files, %0d bytes sent; %0d result beats checked, %0d mismatches",
             files_built, bytes_queued, results_checked, mismatch_count);
    $display("header %0d, data %0d, truncated %0d, ignored %0d, other errors %0d",
             status_seen[wavp_pkg::ST_HEADER], status_seen[wavp_pkg::ST_DATA],
             status_seen[wavp_pkg::ST_TRUNC], status_seen[wavp_pkg::ST_IGNORED],
             results_checked - status_seen[wavp_pkg::ST_HEADER]
               - status_seen[wavp_pkg::ST_DATA] - status_seen[wavp_pkg::ST_TRUNC]
               - status_seen[wavp_pkg::ST_IGNORED]);
    if (mismatch_count == 0 && parsed_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
